/* rtl/rgb_to_hsv_converter_macros.svh */
// Assertion macros shared by the RGB to HSV converter checker.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Clocked assertion, off while reset is active.
`define RGBHSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also runs during reset.
`define RGBHSV_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/rgbhsv_pkg.sv */
// Types and constants for the RGB to HSV converter.
package rgbhsv_pkg;

  localparam int unsigned PIX_W              = 8;
  localparam int unsigned HUE_W              = 15;
  localparam int unsigned COMPONENT_BITS_DEF = 8;
  localparam int unsigned HUE_FRAC_BITS_DEF  = 6;
  localparam logic [PIX_W-1:0] GRAY_THR_RESET = 8'd1;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] brightness;
    logic [PIX_W-1:0] alpha_out;
  } pixel_out_t;

endpackage

/* rtl/rgb_to_hsv_converter.sv */
// RGB to HSV converter: top level with min/max, numerator and divider pipeline.
// Throughput: one pixel per cycle while the output is not stalled; the two divisions run one quotient bit per stage.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and sets the gray threshold to 1.
module rgb_to_hsv_converter #(
  parameter int unsigned COMPONENT_BITS = rgbhsv_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned HUE_FRAC_BITS  = rgbhsv_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rgbhsv_pkg::PIX_W-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rgbhsv_pkg::pixel_in_t             in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rgbhsv_pkg::pixel_out_t            out_data_o
);

  import rgbhsv_pkg::*;

  localparam int unsigned C    = COMPONENT_BITS;
  localparam int unsigned CMAX = (1 << C) - 1;
  localparam int unsigned HU   = 60 * (1 << HUE_FRAC_BITS);
  localparam int unsigned HQ   = $clog2(HU + 1);
  localparam int unsigned NQ   = (C > HQ) ? C : HQ;
  localparam int unsigned SNW  = 2 * C;
  localparam int unsigned HNW  = HQ + C;
  localparam int unsigned HW   = $clog2(6 * HU);
  localparam int unsigned EXW  = (C > PIX_W) ? C : PIX_W;
  localparam int unsigned HXW  = (HW > HUE_W) ? HW : HUE_W;
  localparam int unsigned NS   = NQ + 4;

  typedef struct packed {
    logic [C-1:0]     r;
    logic [C-1:0]     g;
    logic [C-1:0]     b;
    logic [C-1:0]     mx;
    logic [C-1:0]     mn;
    sector_e          sector;
    logic [PIX_W-1:0] alpha;
  } s1_t;

  typedef struct packed {
    logic [C-1:0]     mx;
    logic [C-1:0]     delta;
    logic [C-1:0]     mag;
    logic             neg;
    logic             gray;
    sector_e          sector;
    logic [PIX_W-1:0] alpha;
  } s2_t;

  typedef struct packed {
    logic [SNW-1:0]   srem;
    logic [C-1:0]     sq;
    logic [HNW-1:0]   hrem;
    logic [C-1:0]     hden;
    logic [HQ-1:0]    hq;
    logic [C-1:0]     mx;
    logic             neg;
    logic             gray;
    sector_e          sector;
    logic [PIX_W-1:0] alpha;
  } div_t;

  // One restoring step for each quotient; bit position bpos of both.
  function automatic div_t div_step(div_t cur, int unsigned bpos);
    div_t           nxt;
    logic [SNW-1:0] s_sub;
    logic [HNW-1:0] h_sub;
    nxt = cur;
    if (bpos < C) begin
      s_sub = SNW'(cur.mx) << bpos;
      if (cur.srem >= s_sub) begin
        nxt.srem = cur.srem - s_sub;
        nxt.sq   = {cur.sq[C-2:0], 1'b1};
      end else begin
        nxt.sq   = {cur.sq[C-2:0], 1'b0};
      end
    end
    if (bpos < HQ) begin
      h_sub = HNW'(cur.hden) << bpos;
      if (cur.hrem >= h_sub) begin
        nxt.hrem = cur.hrem - h_sub;
        nxt.hq   = {cur.hq[HQ-2:0], 1'b1};
      end else begin
        nxt.hq   = {cur.hq[HQ-2:0], 1'b0};
      end
    end
    return nxt;
  endfunction

  logic             en;
  logic [NS-1:0]    vld_q;
  logic [PIX_W-1:0] gray_thr_q;

  s1_t        s1_d, s1_q;
  s2_t        s2_d, s2_q;
  div_t       div0_d;
  div_t       div_q   [NQ+1];
  div_t       div_nxt [NQ];
  pixel_out_t out_d, out_q;

  assign en          = !(vld_q[NS-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NS-1];
  assign out_data_o  = out_q;

  // Stage 1: max, min and sector.
  logic [EXW-1:0] r_ext, g_ext, b_ext;
  logic [C-1:0]   r, g, b;
  logic           r_is_max, g_is_max, r_is_min, g_is_min;

  always_comb begin
    r_ext    = EXW'(in_data_i.red);
    g_ext    = EXW'(in_data_i.green);
    b_ext    = EXW'(in_data_i.blue);
    r        = r_ext[C-1:0];
    g        = g_ext[C-1:0];
    b        = b_ext[C-1:0];
    r_is_max = (r >= g) && (r >= b);
    g_is_max = (g >= b);
    r_is_min = (r <= g) && (r <= b);
    g_is_min = (g <= b);
    s1_d.r     = r;
    s1_d.g     = g;
    s1_d.b     = b;
    s1_d.alpha = in_data_i.alpha_in;
    if (r_is_max) begin
      s1_d.mx     = r;
      s1_d.sector = SEC_RED;
    end else if (g_is_max) begin
      s1_d.mx     = g;
      s1_d.sector = SEC_GREEN;
    end else begin
      s1_d.mx     = b;
      s1_d.sector = SEC_BLUE;
    end
    if (r_is_min) begin
      s1_d.mn = r;
    end else if (g_is_min) begin
      s1_d.mn = g;
    end else begin
      s1_d.mn = b;
    end
  end

  // Stage 2: delta, gray test, sector difference as sign and magnitude.
  logic [C-1:0] dif_a, dif_b;

  always_comb begin
    case (s1_q.sector)
      SEC_RED: begin
        dif_a = s1_q.g;
        dif_b = s1_q.b;
      end
      SEC_GREEN: begin
        dif_a = s1_q.b;
        dif_b = s1_q.r;
      end
      default: begin
        dif_a = s1_q.r;
        dif_b = s1_q.g;
      end
    endcase
    s2_d.mx     = s1_q.mx;
    s2_d.sector = s1_q.sector;
    s2_d.alpha  = s1_q.alpha;
    s2_d.delta  = s1_q.mx - s1_q.mn;
    s2_d.neg    = dif_a < dif_b;
    s2_d.mag    = s2_d.neg ? (dif_b - dif_a) : (dif_a - dif_b);
    s2_d.gray   = (EXW'(s2_d.delta) < EXW'(gray_thr_q)) || (s2_d.delta == '0);
  end

  // Stage 3: scaled numerators.
  always_comb begin
    div0_d.srem   = SNW'(s2_q.delta) * SNW'(CMAX);
    div0_d.sq     = '0;
    div0_d.hrem   = HNW'(s2_q.mag) * HNW'(HU);
    div0_d.hden   = s2_q.delta;
    div0_d.hq     = '0;
    div0_d.mx     = s2_q.mx;
    div0_d.neg    = s2_q.neg;
    div0_d.gray   = s2_q.gray;
    div0_d.sector = s2_q.sector;
    div0_d.alpha  = s2_q.alpha;
  end

  // Divider stages, most significant quotient bit first.
  always_comb begin
    for (int unsigned k = 0; k < NQ; k++) begin
      div_nxt[k] = div_step(div_q[k], NQ - 1 - k);
    end
  end

  // Output stage: floor correction, sector offset, wrap.
  div_t           fin;
  logic           adj;
  logic [HW-1:0]  qa, base, hue_full;
  logic [HXW-1:0] hue_ext;
  logic [EXW-1:0] sat_ext, mx_ext;

  always_comb begin
    fin = div_q[NQ];
    adj = fin.neg && (fin.hrem != '0);
    qa  = HW'(fin.hq) + HW'(adj);
    case (fin.sector)
      SEC_RED:   base = fin.neg ? HW'(6 * HU) : '0;
      SEC_GREEN: base = HW'(2 * HU);
      default:   base = HW'(4 * HU);
    endcase
    hue_full = fin.neg ? (base - qa) : (base + qa);
    hue_ext  = fin.gray ? '0 : HXW'(hue_full);
    sat_ext  = fin.gray ? '0 : EXW'(fin.sq);
    mx_ext   = EXW'(fin.mx);
    out_d.hue        = hue_ext[HUE_W-1:0];
    out_d.saturation = sat_ext[PIX_W-1:0];
    out_d.brightness = mx_ext[PIX_W-1:0];
    out_d.alpha_out  = fin.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      gray_thr_q <= GRAY_THR_RESET;
    end else begin
      if (en) begin
        vld_q <= {vld_q[NS-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        gray_thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      div_q[0] <= div0_d;
      for (int unsigned k = 0; k < NQ; k++) begin
        div_q[k+1] <= div_nxt[k];
      end
      out_q    <= out_d;
    end
  end

endmodule

/* rtl/rgbhsv_checker.sv */
// Port-level checker for the RGB to HSV converter, bound to the top level.
`include "rgb_to_hsv_converter_macros.svh"

module rgbhsv_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input rgbhsv_pkg::pixel_out_t out_data_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  // stalled result transaction holds
  `RGBHSV_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "output changed while stalled")

  // input only backs up when the output is full and stalled
  `RGBHSV_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output stall")

  // free-flowing output never blocks a transaction
  `RGBHSV_ASSERT(a_accept_free, in_valid_i && !(out_valid_o && out_stall_i) |-> in_xfer, "input refused while output free")

  // no result right after reset
  `RGBHSV_ASSERT_NR(a_reset_empty, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_rgbhsv_checker (.*);

/* tb/sv/hsv_conversion_checker.sv */
// Checker for the RGB to HSV converter: predicts each pixel's HSV result and compares.
`timescale 1ns / 100ps
module hsv_conversion_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rgbhsv_pkg::PIX_W-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  rgbhsv_pkg::pixel_in_t            in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  rgbhsv_pkg::pixel_out_t           out_data_i,
  output int unsigned                      results_o,
  output int unsigned                      mismatches_o
);

  import rgbhsv_pkg::*;

  localparam int CMAX     = (1 << COMPONENT_BITS_DEF) - 1;
  localparam int HUE_UNIT = 60 << HUE_FRAC_BITS_DEF;

  logic [PIX_W-1:0] gray_thr;
  pixel_out_t       hsv_expected_q[$];
  pixel_out_t       want;
  int unsigned      bad_fields;

  function automatic int floor_quot(int num, int den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic pixel_out_t hsv_of_pixel(pixel_in_t px, logic [PIX_W-1:0] thr);
    int         r, g, b, vmax, vmin, delta, hue, sat;
    sector_e    sector;
    pixel_out_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    vmax = (r > g) ? r : g;
    vmax = (vmax > b) ? vmax : b;
    vmin = (r < g) ? r : g;
    vmin = (vmin < b) ? vmin : b;
    delta = vmax - vmin;
    hue = 0;
    sat = 0;
    if (delta >= int'(thr) && vmax != 0 && delta != 0) begin
      sat = (CMAX * delta) / vmax;
      if (r == vmax) sector = SEC_RED;
      else if (g == vmax) sector = SEC_GREEN;
      else sector = SEC_BLUE;
      case (sector)
        SEC_RED:   hue = floor_quot(HUE_UNIT * (g - b), delta);
        SEC_GREEN: hue = 2 * HUE_UNIT + floor_quot(HUE_UNIT * (b - r), delta);
        default:   hue = 4 * HUE_UNIT + floor_quot(HUE_UNIT * (r - g), delta);
      endcase
      if (hue < 0) hue += 6 * HUE_UNIT;
    end
    res.hue        = hue[HUE_W-1:0];
    res.saturation = sat[PIX_W-1:0];
    res.brightness = vmax[PIX_W-1:0];
    res.alpha_out  = px.alpha_in;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_thr     <= GRAY_THR_RESET;
      hsv_expected_q.delete();
      results_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (hsv_expected_q.size() == 0) begin
          $error("result with no pixel pending: %p", out_data_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = hsv_expected_q.pop_front();
          bad_fields = 0;
          if (out_data_i.hue !== want.hue) begin
            $error("hue: expected %0d, actual %0d", want.hue, out_data_i.hue);
            bad_fields++;
          end
          if (out_data_i.saturation !== want.saturation) begin
            $error("saturation: expected %0d, actual %0d", want.saturation,
                   out_data_i.saturation);
            bad_fields++;
          end
          if (out_data_i.brightness !== want.brightness) begin
            $error("brightness: expected %0d, actual %0d", want.brightness,
                   out_data_i.brightness);
            bad_fields++;
          end
          if (out_data_i.alpha_out !== want.alpha_out) begin
            $error("alpha_out: expected %0d, actual %0d", want.alpha_out,
                   out_data_i.alpha_out);
            bad_fields++;
          end
          mismatches_o <= mismatches_o + bad_fields;
        end
      end
      if (in_valid_i && !in_stall_i) hsv_expected_q.push_back(hsv_of_pixel(in_data_i, gray_thr));
      if (cfg_we_i) gray_thr <= cfg_wdata_i;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the RGB to HSV converter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import rgbhsv_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int LONG_HOLD       = 120;
  localparam int ITEMS_PER_PHASE = 275;
  localparam int RANDOM_PHASES   = 6;

  typedef enum int {IDLE_NONE, IDLE_RANDOM, IDLE_BURSTY} idle_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [PIX_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  pixel_in_t        in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  pixel_out_t       out_data_o;

  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned idle_cycles;
  idle_mode_e  sender_mode;
  idle_mode_e  receiver_mode;
  bit          hold_outputs;

  rgb_to_hsv_converter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  hsv_conversion_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .results_o    (results_seen),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int draw_wait(idle_mode_e mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_RANDOM: return $urandom_range(0, 14);
      default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] near_level(int base);
    int v;
    v = base + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] rail_level();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic pixel_in_t random_pixel();
    pixel_in_t px;
    int        base;
    int        peak;
    int        pick;
    px = pixel_in_t'($urandom);
    pick = $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      4: begin
        base = $urandom_range(0, 255);
        px.red   = near_level(base);
        px.green = near_level(base);
        px.blue  = near_level(base);
      end
      5: begin
        // two components share the maximum
        peak = $urandom_range(1, 255);
        px.red   = PIX_W'(peak);
        px.green = PIX_W'(peak);
        px.blue  = PIX_W'($urandom_range(0, peak));
        if (pick == 1) {px.red, px.green, px.blue} = {px.blue, px.red, px.green};
        if (pick == 2) {px.red, px.green, px.blue} = {px.green, px.blue, px.red};
      end
      6: begin
        px.red   = rail_level();
        px.green = rail_level();
        px.blue  = rail_level();
      end
      7: begin
        px.red   = PIX_W'($urandom_range(0, 7));
        px.green = PIX_W'($urandom_range(0, 7));
        px.blue  = PIX_W'($urandom_range(0, 7));
      end
      8: begin
        case (pick)
          0:       px.red   = 8'd255;
          1:       px.green = 8'd255;
          default: px.blue  = 8'd255;
        endcase
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic send_pixel(pixel_in_t px);
    int gap;
    gap = draw_wait(sender_mode);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    pixels_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_seen != pixels_sent) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [PIX_W-1:0] thr);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // receiver: random stall before each transaction, one long hold-off on request
  initial begin
    int hold;
    bit hold_done;
    hold_done   = 1'b0;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = draw_wait(receiver_mode);
      if (hold_outputs && !hold_done) begin
        hold      = LONG_HOLD;
        hold_done = 1'b1;
      end
      repeat (hold) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL rgb_to_hsv_converter");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    logic [PIX_W-1:0] thr;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    in_data_i     <= '0;
    sender_mode   = IDLE_NONE;
    receiver_mode = IDLE_NONE;
    hold_outputs  = 1'b0;
    pixels_sent   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold: primaries, ties, wrap, gray and tiny values
    send_pixel(pixel_in_t'{8'd0,   8'd0,   8'd0,   8'd0});
    send_pixel(pixel_in_t'{8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel(pixel_in_t'{8'd255, 8'd0,   8'd0,   8'h55});
    send_pixel(pixel_in_t'{8'd0,   8'd255, 8'd0,   8'hAA});
    send_pixel(pixel_in_t'{8'd0,   8'd0,   8'd255, 8'd0});
    send_pixel(pixel_in_t'{8'd255, 8'd255, 8'd0,   8'd1});
    send_pixel(pixel_in_t'{8'd0,   8'd255, 8'd255, 8'd128});
    send_pixel(pixel_in_t'{8'd255, 8'd0,   8'd255, 8'd254});
    send_pixel(pixel_in_t'{8'd128, 8'd128, 8'd128, 8'd7});
    send_pixel(pixel_in_t'{8'd100, 8'd101, 8'd100, 8'd9});
    send_pixel(pixel_in_t'{8'd1,   8'd0,   8'd0,   8'd3});
    send_pixel(pixel_in_t'{8'd200, 8'd10,  8'd30,  8'd40});
    send_pixel(pixel_in_t'{8'd10,  8'd200, 8'd30,  8'd50});
    send_pixel(pixel_in_t'{8'd30,  8'd10,  8'd200, 8'd60});
    send_pixel(pixel_in_t'{8'd255, 8'd254, 8'd253, 8'd70});
    send_pixel(pixel_in_t'{8'd0,   8'd1,   8'd255, 8'd80});
    drain_results();

    // zero threshold: only a zero delta is gray
    write_threshold(8'd0);
    send_pixel(pixel_in_t'{8'd50,  8'd50,  8'd50,  8'd11});
    send_pixel(pixel_in_t'{8'd0,   8'd0,   8'd0,   8'd12});
    send_pixel(pixel_in_t'{8'd3,   8'd2,   8'd1,   8'd13});
    drain_results();

    write_threshold(8'd255);
    send_pixel(pixel_in_t'{8'd255, 8'd0,   8'd0,   8'd21});
    send_pixel(pixel_in_t'{8'd255, 8'd0,   8'd128, 8'd22});
    send_pixel(pixel_in_t'{8'd254, 8'd0,   8'd0,   8'd23});
    send_pixel(pixel_in_t'{8'd0,   8'd255, 8'd255, 8'd24});
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        2:       thr = 8'd1;
        3:       thr = PIX_W'($urandom_range(0, 255));
        4:       thr = PIX_W'($urandom_range(0, 15));
        default: thr = PIX_W'($urandom_range(0, 40));
      endcase
      write_threshold(thr);
      sender_mode   = idle_mode_e'(p % 3);
      receiver_mode = idle_mode_e'((p + 1) % 3);
      // sender runs without gaps here, so the long hold-off backs up the pipeline
      hold_outputs  = (p == 3);
      repeat (ITEMS_PER_PHASE) send_pixel(random_pixel());
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && results_seen == pixels_sent)
      $display("PASS rgb_to_hsv_converter");
    else
      $display("FAIL rgb_to_hsv_converter");
    $finish;
  end

endmodule
